### src/sglb_pkg.sv
// Shared constants and types for the scatter-gather list builder.
package sglb_pkg;

    localparam int FRAME_DEPTH = 64;
    localparam int MAX_ENTRIES = 32;
    localparam int PAGE_BITS   = 12;

    localparam int FRAME_AW = $clog2(FRAME_DEPTH);
    localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
    localparam int FRAME_W  = 52;
    localparam int ADDR_W   = 64;
    localparam int LEN_W    = 32;
    localparam int CNT_W    = 6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_NOSPC = 2'd3;

    localparam logic [2:0] REG_FPO   = 3'd0;
    localparam logic [2:0] REG_MAP   = 3'd1;
    localparam logic [2:0] REG_RING  = 3'd2;
    localparam logic [2:0] REG_PAGES = 3'd3;
    localparam logic [2:0] REG_LIMIT = 3'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BUILD = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } entry_t;

endpackage

### src/sglb_entry_ram.sv
// Entry store: buffered scatter-gather entries, one write port and one registered read port.
module sglb_entry_ram
    import sglb_pkg::*;
(
    input  logic                clk,
    input  logic                we,
    input  logic [ENTRY_AW-1:0] waddr,
    input  entry_t              wdata,
    input  logic [ENTRY_AW-1:0] raddr,
    output entry_t              rdata
);

    entry_t mem [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/scatter_gather_list_builder.sv
// Top level of the scatter-gather list builder: validation, page walk and result output.
//
//  channel   direction  signals
//  request   in         valid, ready, opcode, page_slot, frame_number, region_*, wrap_allowed
//  result    out        out_valid, out_ready, seg_addr, seg_len, status, seg_count, last
//  config    in         cfg_we, cfg_index, cfg_data
//
// A load request writes one frame table slot while the block is idle. A build request runs a
// check, then per walked page a frame table read and an entry merge, a step per range end,
// and then one result per entry, each read from the registered entry store before it is
// sent and held back while the result side stalls. Reset clears control state only; both
// memories hold garbage until written. The result register holds its value while out_ready
// is low.
module scatter_gather_list_builder
    import sglb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 ready,
    input  logic                 opcode,
    input  logic [5:0]           page_slot,
    input  logic [FRAME_W-1:0]   frame_number,
    input  logic [31:0]          region_start,
    input  logic [31:0]          region_length,
    input  logic                 wrap_allowed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    seg_addr,
    output logic [LEN_W-1:0]     seg_len,
    output logic [1:0]           status,
    output logic [CNT_W-1:0]     seg_count,
    output logic                 last,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_ERR   = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;

    localparam logic [33:0] PAGE_BYTES = 34'd1 << PAGE_BITS;

    logic [11:0] fpo_reg;
    logic [31:0] map_reg;
    logic [31:0] ring_reg;
    logic [6:0]  pages_reg;
    logic [5:0]  limit_reg;

    logic [2:0]  state_reg;
    logic [33:0] pos_reg;
    logic [32:0] left_reg;
    logic [32:0] second_reg;
    logic [31:0] start_reg;
    logic [31:0] len_reg;
    logic        wrap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] emit_reg;
    logic [1:0]  err_reg;
    entry_t      prev_reg;
    logic [CNT_W-1:0] lim_eff_reg;
    logic [15:0] poff_reg;
    logic [32:0] chunk_reg;

    logic [FRAME_W-1:0] frame_mem [FRAME_DEPTH];
    logic [FRAME_W-1:0] frame_rd;

    logic        ram_we;
    logic [ENTRY_AW-1:0] ram_waddr;
    entry_t      ram_wdata;
    logic [ENTRY_AW-1:0] ram_raddr;
    entry_t      ram_rdata;

    logic        out_valid_reg;
    logic        out_free;
    logic        out_load;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = out_free && (state_reg == S_EMIT || state_reg == S_ERR);
    assign ready     = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpo_reg   <= '0;
            map_reg   <= '0;
            ring_reg  <= '0;
            pages_reg <= '0;
            limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FPO:   fpo_reg   <= cfg_data[11:0];
                REG_MAP:   map_reg   <= cfg_data;
                REG_RING:  ring_reg  <= cfg_data;
                REG_PAGES: pages_reg <= cfg_data[6:0];
                REG_LIMIT: limit_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic [FRAME_AW-1:0] frame_raddr;
    assign frame_raddr = pos_reg[PAGE_BITS +: FRAME_AW];

    always_ff @(posedge clk)
    begin
        if (valid && ready && opcode == OP_LOAD)
        begin
            frame_mem[page_slot[FRAME_AW-1:0]] <= frame_number;
        end
        frame_rd <= frame_mem[frame_raddr];
    end

    sglb_entry_ram u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Validation terms.
    logic [32:0] end_w;
    logic [32:0] pages_need;
    logic        inval;
    assign end_w      = {1'b0, start_reg} + {1'b0, len_reg};
    assign pages_need = 33'(({21'd0, fpo_reg} + {1'b0, map_reg} + 33'(PAGE_BYTES - 34'd1))
                            >> PAGE_BITS);
    assign inval = (pages_reg == '0) || (ring_reg == '0) || (start_reg >= ring_reg)
                || (len_reg == '0) || (len_reg > ring_reg) || (ring_reg > map_reg);

    // Page walk terms.
    logic [33:0] pidx;
    logic [15:0] poff;
    logic [33:0] room;
    logic [32:0] chunk;
    assign pidx  = pos_reg >> PAGE_BITS;
    assign poff  = 16'(pos_reg & (PAGE_BYTES - 34'd1));
    assign room  = PAGE_BYTES - {18'd0, poff};
    assign chunk = ({1'b0, left_reg} < room) ? left_reg : room[32:0];

    logic [ADDR_W-1:0] paddr;
    logic [64:0]       prev_end;
    logic [33:0]       merged;
    logic              frame_big;
    assign frame_big = (PAGE_BITS > 12) && ((frame_rd >> (ADDR_W - PAGE_BITS)) != '0);
    assign paddr     = (ADDR_W'(frame_rd) << PAGE_BITS) + ADDR_W'(poff_reg);
    assign prev_end  = {1'b0, prev_reg.addr} + {33'd0, prev_reg.len};
    assign merged    = {2'b0, prev_reg.len} + {1'b0, chunk_reg};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ENTRY_AW'(count_reg);
        ram_wdata.addr = paddr;
        ram_wdata.len  = chunk_reg[31:0];
        ram_raddr = ENTRY_AW'(emit_reg);
        if (state_reg == S_MERGE && !frame_big)
        begin
            if (count_reg != '0 && !prev_end[64] && prev_end[63:0] == paddr)
            begin
                if (merged <= 34'hffffffff)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = ENTRY_AW'(count_reg - 1'b1);
                    ram_wdata.addr = prev_reg.addr;
                    ram_wdata.len  = merged[31:0];
                end
            end
            else if (count_reg < lim_eff_reg)
            begin
                ram_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            emit_reg      <= '0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (valid && opcode == OP_BUILD)
                    begin
                        start_reg   <= region_start;
                        len_reg     <= region_length;
                        wrap_reg    <= wrap_allowed;
                        count_reg   <= '0;
                        lim_eff_reg <= (limit_reg > CNT_W'(MAX_ENTRIES))
                                       ? CNT_W'(MAX_ENTRIES) : limit_reg;
                        state_reg   <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    pos_reg    <= {22'd0, fpo_reg} + {2'd0, start_reg};
                    second_reg <= '0;
                    if (inval)
                    begin
                        err_reg   <= ST_INVAL;
                        state_reg <= S_ERR;
                    end
                    else if (pages_need > {26'd0, pages_reg})
                    begin
                        err_reg   <= ST_RANGE;
                        state_reg <= S_ERR;
                    end
                    else if (end_w <= {1'b0, ring_reg})
                    begin
                        left_reg  <= {1'b0, len_reg};
                        state_reg <= S_READ;
                    end
                    else if (!wrap_reg)
                    begin
                        err_reg   <= ST_INVAL;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        left_reg   <= {1'b0, ring_reg} - {1'b0, start_reg};
                        second_reg <= end_w - {1'b0, ring_reg};
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (left_reg == '0)
                    begin
                        if (second_reg != '0)
                        begin
                            pos_reg    <= {22'd0, fpo_reg};
                            left_reg   <= second_reg;
                            second_reg <= '0;
                        end
                        else
                        begin
                            emit_reg  <= '0;
                            state_reg <= S_DRAIN;
                        end
                    end
                    else if (pidx >= {27'd0, pages_reg} || pidx >= 34'(FRAME_DEPTH))
                    begin
                        err_reg   <= ST_RANGE;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        poff_reg  <= poff;
                        chunk_reg <= chunk;
                        pos_reg   <= pos_reg + {1'b0, chunk};
                        left_reg  <= left_reg - chunk;
                        state_reg <= S_MERGE;
                    end
                end
                S_MERGE:
                begin
                    state_reg <= S_READ;
                    if (frame_big)
                    begin
                        err_reg   <= ST_INVAL;
                        state_reg <= S_ERR;
                    end
                    else if (count_reg != '0 && !prev_end[64] && prev_end[63:0] == paddr)
                    begin
                        if (merged > 34'hffffffff)
                        begin
                            err_reg   <= ST_INVAL;
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            prev_reg.len <= merged[31:0];
                        end
                    end
                    else if (count_reg >= lim_eff_reg)
                    begin
                        err_reg   <= ST_NOSPC;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        prev_reg.addr <= paddr;
                        prev_reg.len  <= chunk_reg[31:0];
                        count_reg     <= count_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    // Wait state for the registered entry read to settle.
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        seg_addr      <= ram_rdata.addr;
                        seg_len       <= ram_rdata.len;
                        status        <= ST_OK;
                        seg_count     <= count_reg;
                        last          <= (emit_reg + 1'b1 == count_reg);
                        emit_reg      <= emit_reg + 1'b1;
                        if (emit_reg + 1'b1 == count_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        seg_addr      <= '0;
                        seg_len       <= '0;
                        status        <= err_reg;
                        seg_count     <= '0;
                        last          <= 1'b1;
                        count_reg     <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
